// ===== rtl/frequency_ordered_counter_table_core_macros.svh =====
// Assertion macros used by the checker of the counter table core.
`ifndef FREQUENCY_ORDERED_COUNTER_TABLE_CORE_MACROS_SVH
`define FREQUENCY_ORDERED_COUNTER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FOCT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("counter table check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FOCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("counter table check failed");

`endif

// ===== rtl/foct_pkg.sv =====
// Package: shared constants, codes and bundle types of the counter table core.
package foct_pkg;

  localparam int CAP    = 1024;
  localparam int IDX_W  = $clog2(CAP);
  localparam int USED_W = $clog2(CAP + 1);
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 32;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_RANK  = 2'd1,
    CMD_SLOT  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        count;
    logic [IDX_W-1:0]        slot;
  } entry_t;

  // Broadcast at the transfer edge: each cell latches its select bit.
  typedef struct packed {
    logic                    load;
    cmd_t                    cmd;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        pos;
    logic [USED_W-1:0]       used;
  } probe_t;

  // Broadcast in the update cycle.
  typedef struct packed {
    logic                    move;
    logic                    append;
    logic [CNT_W-1:0]        newc;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        mslot;
  } upd_t;

endpackage

// ===== rtl/foct_cell.sv =====
// One rank position of the table: entry storage, match and shift logic.
module foct_cell (
  input  logic                         clk,
  input  logic [foct_pkg::IDX_W-1:0]   index,
  input  foct_pkg::probe_t             probe,
  input  foct_pkg::upd_t               upd,
  input  logic                         pre,
  input  logic                         lt_prev,
  input  foct_pkg::entry_t             nb,
  output logic                         lt,
  output logic                         sel,
  output foct_pkg::entry_t             ent,
  output foct_pkg::entry_t             ent_masked
);

  logic valid;
  logic sel_next;

  assign valid = {1'b0, index} < probe.used;
  assign lt    = valid && (ent.count < upd.newc);
  assign ent_masked = sel ? ent : '0;

  always_comb begin
    case (probe.cmd)
      foct_pkg::CMD_ADD:  sel_next = valid && (ent.value == probe.value);
      foct_pkg::CMD_RANK: sel_next = valid && (index == probe.pos);
      foct_pkg::CMD_SLOT: sel_next = valid && (ent.slot == probe.pos);
      default:            sel_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (probe.load) begin
      sel <= sel_next;
    end
    if (upd.move && !pre) begin
      if (lt && !lt_prev) begin
        ent <= '{value: upd.value, count: upd.newc, slot: upd.mslot};
      end else if (lt_prev) begin
        ent <= nb;
      end
    end else if (upd.append && ({1'b0, index} == probe.used)) begin
      ent <= '{value: upd.value, count: foct_pkg::CNT_W'(1), slot: index};
    end
  end

endmodule

// ===== rtl/frequency_ordered_counter_table_core.sv =====
// Top level: frequency-ordered counter table built as a chain of rank cells.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------------
//   request | req_valid | req_stall | cmd, sample_value, position
//   result  | rsp_valid | rsp_stall | entry_value_out, entry_count_out, entry_valid,
//           |           |           | total_adds, dropped
//
// For each command, the transfer edge latches a select bit in every
// cell, and the update state then updates the chain and loads the result register.
// The chain is ranked by count, so one add must finish before the next compare.
// A pending result held by rsp_stall holds the update cycle until it drains.
// rst clears the state, fill count, add total and result valid; entries are
// only read below the fill count and need no clearing.
module frequency_ordered_counter_table_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [1:0]                          cmd,
  input  logic signed [31:0]                  sample_value,
  input  logic [9:0]                          position,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic signed [31:0]                  entry_value_out,
  output logic [31:0]                         entry_count_out,
  output logic                                entry_valid,
  output logic [31:0]                         total_adds,
  output logic                                dropped
);

  localparam logic [foct_pkg::USED_W-1:0] CAP_USED = foct_pkg::USED_W'(foct_pkg::CAP);
  localparam logic [foct_pkg::CNT_W-1:0]  CNT_MAX  = '1;

  foct_pkg::state_t state, state_next;
  foct_pkg::cmd_t   cmd_q;
  logic signed [31:0] value_q;

  logic [foct_pkg::USED_W-1:0] used, used_next;
  logic [31:0]                 add_total, add_total_next;

  foct_pkg::probe_t probe;
  foct_pkg::upd_t   upd;

  logic                     accept, go;
  logic [foct_pkg::CAP-1:0] sel_vec, lt_vec, pre_vec;
  foct_pkg::entry_t         ent_vec    [foct_pkg::CAP];
  foct_pkg::entry_t         masked_vec [foct_pkg::CAP];
  foct_pkg::entry_t         red;
  logic                     hit, sat, room;

  logic signed [31:0] res_value;
  logic [31:0]        res_count;
  logic               res_valid, res_drop;

  assign accept = req_valid && !req_stall;

  // Probe: compare against the live request at the transfer edge.
  assign probe = '{load: accept, cmd: foct_pkg::cmd_t'(cmd), value: sample_value,
                   pos: position[foct_pkg::IDX_W-1:0], used: used};

  // Matched entry and hit flag: select bits are one-hot, so OR the masked entries.
  always_comb begin
    red = '0;
    for (int i = 0; i < foct_pkg::CAP; i++) begin
      red = red | masked_vec[i];
    end
  end
  assign hit  = |sel_vec;
  assign sat  = (red.count == CNT_MAX);
  assign room = (used != CAP_USED);

  // Prefix OR of select bits, excluding each cell's own: true past the match.
  always_comb begin
    pre_vec = sel_vec << 1;
    for (int k = 1; k < foct_pkg::CAP; k = k * 2) begin
      pre_vec = pre_vec | (pre_vec << k);
    end
  end

  assign upd = '{move:   go && (cmd_q == foct_pkg::CMD_ADD) && hit && !sat,
                 append: go && (cmd_q == foct_pkg::CMD_ADD) && !hit && room,
                 newc:   red.count + 32'd1,
                 value:  value_q,
                 mslot:  red.slot};

  for (genvar i = 0; i < foct_pkg::CAP; i++) begin : g_cell
    foct_pkg::entry_t nb;
    logic             ltp;
    if (i == 0) begin : g_head
      assign nb  = '0;
      assign ltp = 1'b0;
    end else begin : g_body
      assign nb  = ent_vec[i-1];
      assign ltp = lt_vec[i-1];
    end
    foct_cell u_cell (
      .clk        (clk),
      .index      (foct_pkg::IDX_W'(i)),
      .probe      (probe),
      .upd        (upd),
      .pre        (pre_vec[i]),
      .lt_prev    (ltp),
      .nb         (nb),
      .lt         (lt_vec[i]),
      .sel        (sel_vec[i]),
      .ent        (ent_vec[i]),
      .ent_masked (masked_vec[i])
    );
  end

  // Control: idle waits for a transfer; update waits for a free result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= foct_pkg::ST_IDLE;
      used      <= '0;
      add_total <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      add_total <= add_total_next;
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    req_stall      = 1'b0;
    go             = 1'b0;
    used_next      = used;
    add_total_next = add_total;
    res_value      = '0;
    res_count      = '0;
    res_valid      = 1'b0;
    res_drop       = 1'b0;
    unique case (state)
      foct_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = foct_pkg::ST_UPD;
        end
      end
      foct_pkg::ST_UPD: begin
        req_stall = 1'b1;
        go        = !rsp_valid || !rsp_stall;
        if (go) begin
          state_next = foct_pkg::ST_IDLE;
        end
      end
      default: state_next = foct_pkg::ST_IDLE;
    endcase
    case (cmd_q)
      foct_pkg::CMD_ADD: begin
        if (add_total != 32'hFFFF_FFFF) begin
          add_total_next = add_total + 32'd1;
        end
        if (hit) begin
          res_value = value_q;
          res_count = sat ? red.count : upd.newc;
          res_valid = 1'b1;
        end else if (room) begin
          res_value = value_q;
          res_count = 32'd1;
          res_valid = 1'b1;
          used_next = used + foct_pkg::USED_W'(1);
        end else begin
          res_drop = 1'b1;
        end
      end
      foct_pkg::CMD_CLEAR: begin
        used_next      = '0;
        add_total_next = '0;
      end
      default: begin
        res_value = red.value;
        res_count = red.count;
        res_valid = hit;
      end
    endcase
    if (!go) begin
      used_next      = used;
      add_total_next = add_total;
    end
  end

  // Hold the request fields and the result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= foct_pkg::cmd_t'(cmd);
      value_q <= sample_value;
    end
    if (go) begin
      entry_value_out <= res_value;
      entry_count_out <= res_count;
      entry_valid     <= res_valid;
      total_adds      <= add_total_next;
      dropped         <= res_drop;
    end
  end

endmodule

// ===== rtl/foct_checker.sv =====
// Port checker for the counter table core and its bind.
`include "frequency_ordered_counter_table_core_macros.svh"

module foct_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] entry_value_out,
  input logic [31:0] entry_count_out,
  input logic        entry_valid,
  input logic        dropped
);

  // A stalled result stays put.
  `FOCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(entry_count_out))

  // One command at a time: the cycle after a transfer stalls the request side.
  `FOCT_ASSERT_NEXT(a_one_inflight, req_valid && !req_stall, req_stall)

  // A dropped add reports no entry.
  `FOCT_ASSERT_NOW(a_drop_empty, rsp_valid && dropped,
                   !entry_valid && entry_count_out == 32'd0 && entry_value_out == 32'd0)

  // A reported entry has been counted at least once.
  `FOCT_ASSERT_NOW(a_valid_count, rsp_valid && entry_valid, entry_count_out != 32'd0)

endmodule

bind frequency_ordered_counter_table_core foct_checker u_foct_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req_valid),
  .req_stall       (req_stall),
  .rsp_valid       (rsp_valid),
  .rsp_stall       (rsp_stall),
  .entry_value_out (entry_value_out),
  .entry_count_out (entry_count_out),
  .entry_valid     (entry_valid),
  .dropped         (dropped)
);

// ===== tb/frequency_ordered_counter_table_core_test.sv =====
// Testbench of the counter table core: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module frequency_ordered_counter_table_core_test;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic signed [31:0] value;
    logic [31:0]        count;
    logic               valid;
    logic [31:0]        total;
    logic               dropped;
  } table_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         cmd = foct_pkg::CMD_ADD;
  logic signed [31:0] sample_value = '0;
  logic [9:0]         position = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] entry_value_out;
  logic [31:0]        entry_count_out;
  logic               entry_valid;
  logic [31:0]        total_adds;
  logic               dropped;

  // Predicted table contents.
  logic signed [31:0] tbl_value [foct_pkg::CAP];
  logic [31:0]        tbl_count [foct_pkg::CAP];
  int unsigned        tbl_rank  [foct_pkg::CAP];
  int unsigned        tbl_used = 0;
  logic [31:0]        tbl_adds = '0;

  table_rsp_t   pending_rsp [$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           gaps_on = 1'b0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_cycles = 0;
  int unsigned  burst_left = 0;
  logic signed [31:0] value_pool [16];

  frequency_ordered_counter_table_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: a long hold when requested, else random stalls at the phase rate.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall   <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic table_rsp_t predict_table(foct_pkg::cmd_t c, logic signed [31:0] v,
                                               logic [9:0] p);
    table_rsp_t  r;
    int unsigned s, k, rk, ahead, moved;
    r = '{value: '0, count: '0, valid: 1'b0, total: '0, dropped: 1'b0};
    case (c)
      foct_pkg::CMD_ADD: begin
        if (tbl_adds != CNT_MAX) tbl_adds++;
        s = tbl_used;
        for (k = 0; k < tbl_used; k++)
          if (tbl_value[k] == v) begin
            s = k;
            break;
          end
        if (s == tbl_used) begin
          if (tbl_used >= foct_pkg::CAP) begin
            r.dropped = 1'b1;
          end else begin
            tbl_value[s] = v;
            tbl_count[s] = 1;
            tbl_rank[s]  = s;
            tbl_used++;
            r.value = v;
            r.count = 1;
            r.valid = 1'b1;
          end
        end else begin
          if (tbl_count[s] != CNT_MAX) begin
            tbl_count[s]++;
            rk = 0;
            while (tbl_rank[rk] != s) rk++;
            // move ahead of the first entry with a lower count
            ahead = rk;
            for (k = 0; k < rk; k++)
              if (tbl_count[tbl_rank[k]] < tbl_count[s]) begin
                ahead = k;
                break;
              end
            moved = tbl_rank[rk];
            for (k = rk; k > ahead; k--) tbl_rank[k] = tbl_rank[k-1];
            tbl_rank[ahead] = moved;
          end
          r.value = v;
          r.count = tbl_count[s];
          r.valid = 1'b1;
        end
      end
      foct_pkg::CMD_CLEAR: begin
        tbl_used = 0;
        tbl_adds = '0;
      end
      default: begin
        if (p < tbl_used) begin
          s = (c == foct_pkg::CMD_RANK) ? tbl_rank[p] : p;
          r.value = tbl_value[s];
          r.count = tbl_count[s];
          r.valid = 1'b1;
        end
      end
    endcase
    r.total = tbl_adds;
    return r;
  endfunction

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    table_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("result transfer with no prediction waiting");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (entry_value_out !== want.value) begin
          $error("entry_value_out: expected %0d, got %0d", want.value, entry_value_out);
          fail_count++;
        end
        if (entry_count_out !== want.count) begin
          $error("entry_count_out: expected %0d, got %0d", want.count, entry_count_out);
          fail_count++;
        end
        if (entry_valid !== want.valid) begin
          $error("entry_valid: expected %0b, got %0b", want.valid, entry_valid);
          fail_count++;
        end
        if (total_adds !== want.total) begin
          $error("total_adds: expected %0d, got %0d", want.total, total_adds);
          fail_count++;
        end
        if (dropped !== want.dropped) begin
          $error("dropped: expected %0b, got %0b", want.dropped, dropped);
          fail_count++;
        end
      end
    end
  end

  // Offer one command; return at its transfer edge with valid still high.
  task automatic send_cmd(foct_pkg::cmd_t c, logic signed [31:0] v, logic [9:0] p);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(6, 1);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(12, 1);
      end
      burst_left--;
    end
    req_valid    <= 1'b1;
    cmd          <= c;
    sample_value <= v;
    position     <= p;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp.push_back(predict_table(c, v, p));
  endtask

  // Lower valid and hold until every predicted result has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_reads();
    send_cmd(foct_pkg::CMD_RANK, '0, 10'd0);
    send_cmd(foct_pkg::CMD_SLOT, '0, 10'd0);
    send_cmd(foct_pkg::CMD_RANK, '0, 10'd1023);
    send_cmd(foct_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 10'd1023);
    wait_drained();
  endtask

  task automatic test_directed_adds();
    send_cmd(foct_pkg::CMD_ADD, 32'sh8000_0000, '0);
    send_cmd(foct_pkg::CMD_ADD, 32'sh7FFF_FFFF, '0);
    send_cmd(foct_pkg::CMD_ADD, 32'sd0, '0);
    send_cmd(foct_pkg::CMD_ADD, -32'sd1, '0);
    // tail entry climbs past lower counts; ties keep who got there first
    send_cmd(foct_pkg::CMD_ADD, -32'sd1, '0);
    send_cmd(foct_pkg::CMD_ADD, 32'sd0, '0);
    send_cmd(foct_pkg::CMD_ADD, 32'sd0, '0);
    send_cmd(foct_pkg::CMD_ADD, 32'sh7FFF_FFFF, '0);
    for (int i = 0; i < 5; i++) send_cmd(foct_pkg::CMD_RANK, '0, i[9:0]);
    for (int i = 0; i < 5; i++) send_cmd(foct_pkg::CMD_SLOT, '0, i[9:0]);
    send_cmd(foct_pkg::CMD_CLEAR, '0, '0);
    send_cmd(foct_pkg::CMD_RANK, '0, 10'd0);
    send_cmd(foct_pkg::CMD_ADD, 32'sd5, 10'h3FF);
    wait_drained();
  endtask

  task automatic test_full_table();
    gaps_on   = 1'b1;
    stall_pct = 20;
    send_cmd(foct_pkg::CMD_CLEAR, '0, '0);
    for (int i = 0; i < foct_pkg::CAP; i++)
      send_cmd(foct_pkg::CMD_ADD, $urandom() ^ (i << 20) ^ i, '0);
    // new value into a full table is dropped, a known one still counts
    send_cmd(foct_pkg::CMD_ADD, 32'sh1234_5678 ^ $urandom(), '0);
    send_cmd(foct_pkg::CMD_ADD, tbl_value[foct_pkg::CAP-1], '0);
    send_cmd(foct_pkg::CMD_RANK, '0, 10'd1023);
    send_cmd(foct_pkg::CMD_SLOT, '0, 10'd1023);
    send_cmd(foct_pkg::CMD_RANK, '0, 10'd0);
    send_cmd(foct_pkg::CMD_SLOT, '0, 10'd512);
    wait_drained();
    send_cmd(foct_pkg::CMD_CLEAR, '0, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    // hold the result side long enough that the block stalls its input
    @(posedge clk);
    hold_cycles = 200;
    for (int i = 0; i < 40; i++) send_cmd(foct_pkg::CMD_ADD, i % 7, '0);
    for (int i = 0; i < 8; i++) send_cmd(foct_pkg::CMD_RANK, '0, i[9:0]);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned        pick;
    foct_pkg::cmd_t     c;
    logic signed [31:0] v;
    logic [9:0]         p;
    for (int i = 0; i < 400; i++) begin
      if (i % 100 == 0) begin
        gaps_on   = 1'($urandom_range(1));
        stall_pct = $urandom_range(3) * 20;
        foreach (value_pool[k])
          value_pool[k] = ($urandom_range(1)) ? $urandom() : $urandom_range(40) - 20;
      end
      pick = $urandom_range(99);
      v    = $urandom();
      p    = 10'($urandom());
      if (pick < 50) begin
        c = foct_pkg::CMD_ADD;
        v = value_pool[$urandom_range(15)];
      end else if (pick < 58) begin
        c = foct_pkg::CMD_ADD;
      end else if (pick < 97) begin
        c = (pick < 78) ? foct_pkg::CMD_RANK : foct_pkg::CMD_SLOT;
        if (pick % 5 != 0) p = 10'($urandom_range(tbl_used + 1));
      end else begin
        c = foct_pkg::CMD_CLEAR;
      end
      send_cmd(c, v, p);
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_reads();
    test_directed_adds();
    test_full_table();
    test_backpressure();
    test_random();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/foct_pkg.sv
rtl/foct_cell.sv
rtl/frequency_ordered_counter_table_core.sv
rtl/foct_checker.sv
tb/frequency_ordered_counter_table_core_test.sv
